// ===== src/smid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smid_pkg
// Shared types, encodings and decode tables for the sound MCU instruction
// decoder.
// ----------------------------------------------------------------------------
package smid_pkg;

  localparam int WORD_W   = 16;
  localparam int OPC_W    = 7;
  localparam int FORM_W   = 4;
  localparam int REG_W    = 5;
  localparam int IMM_W    = 12;
  localparam int BRANCH_W = 2;

  // dense opcode map
  localparam logic [OPC_W-1:0] OPC_MISC_BASE  = 7'd0;
  localparam logic [OPC_W-1:0] OPC_REG_BASE   = 7'd20;
  localparam logic [OPC_W-1:0] OPC_MID_BASE   = 7'd39;
  localparam logic [OPC_W-1:0] OPC_MVI        = 7'd46;
  localparam logic [OPC_W-1:0] OPC_JMP        = 7'd47;
  localparam logic [OPC_W-1:0] OPC_CALL       = 7'd48;
  localparam logic [OPC_W-1:0] OPC_K_BASE     = 7'd49;
  localparam logic [OPC_W-1:0] OPC_K_TADI5    = 7'd59;
  localparam logic [OPC_W-1:0] OPC_P_REG_BASE = 7'd60;
  localparam logic [OPC_W-1:0] OPC_P_IMM_BASE = 7'd76;
  localparam logic [OPC_W-1:0] OPC_UNKNOWN    = 7'd127;

  // operand forms
  localparam logic [FORM_W-1:0] FORM_NONE     = 4'd0;
  localparam logic [FORM_W-1:0] FORM_REG      = 4'd1;
  localparam logic [FORM_W-1:0] FORM_IMM      = 4'd2;
  localparam logic [FORM_W-1:0] FORM_REG_IMM  = 4'd3;
  localparam logic [FORM_W-1:0] FORM_A_IMM    = 4'd4;
  localparam logic [FORM_W-1:0] FORM_MD_IMM   = 4'd5;
  localparam logic [FORM_W-1:0] FORM_MD1_IMM  = 4'd6;
  localparam logic [FORM_W-1:0] FORM_HIND_IMM = 4'd7;
  localparam logic [FORM_W-1:0] FORM_H_IMM    = 4'd8;
  localparam logic [FORM_W-1:0] FORM_A_HIND   = 4'd9;
  localparam logic [FORM_W-1:0] FORM_HIND_A   = 4'd10;
  localparam logic [FORM_W-1:0] FORM_A_REG    = 4'd11;
  localparam logic [FORM_W-1:0] FORM_REG_A    = 4'd12;
  localparam logic [FORM_W-1:0] FORM_UNDEF    = 4'd13;

  localparam logic [BRANCH_W-1:0] BR_NONE = 2'd0;
  localparam logic [BRANCH_W-1:0] BR_JUMP = 2'd1;
  localparam logic [BRANCH_W-1:0] BR_CALL = 2'd2;

  // register-mode low nibble selectors
  localparam logic [3:0] RM_A_HIND = 4'h1;
  localparam logic [3:0] RM_HIND_A = 4'h9;
  localparam logic [3:0] RM_A_REG  = 4'h0;
  localparam logic [3:0] RM_REG_A  = 4'h8;

  localparam logic [3:0] K_SEL_LAST  = 4'd9;
  localparam logic [3:0] K_SEL_TADI5 = 4'hC;
  localparam logic [IMM_W-1:0] ROM_LIMIT = 12'd511;
  localparam logic [WORD_W-1:0] REG_KEY_MASK = 16'h0E0F;

  typedef enum logic [2:0] {
    CLS_MISC,
    CLS_REG,
    CLS_MID,
    CLS_MVI,
    CLS_JMP,
    CLS_CALL,
    CLS_K,
    CLS_P
  } cls_t;

  typedef struct packed {
    logic [OPC_W-1:0] opc;
    logic             known;
    logic             reg_used;
  } match_t;

  localparam int MISC_COUNT = 20;
  localparam int REG_COUNT  = 19;
  localparam int MID_COUNT  = 7;

  localparam logic [WORD_W-1:0] MISC_WORDS [MISC_COUNT] = '{
    16'h0000, 16'h0002, 16'h0004, 16'h0005, 16'h0008, 16'h0101, 16'h0201, 16'h0208,
    16'h0401, 16'h0402, 16'h0404, 16'h0408, 16'h0501, 16'h0502, 16'h0504, 16'h050C,
    16'h0604, 16'h0800, 16'h0801, 16'h090F
  };

  localparam logic [WORD_W-1:0] REG_KEYS [REG_COUNT] = '{
    16'h000, 16'h005, 16'h00A, 16'h201, 16'h202, 16'h205, 16'h20A,
    16'h405, 16'h409, 16'h601, 16'h605,
    16'h801, 16'h802, 16'h804, 16'h808, 16'hA01, 16'hA02, 16'hA04, 16'hA08
  };

  localparam logic REG_USES [REG_COUNT] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

  localparam logic [4:0] MID_KEYS [MID_COUNT] = '{
    5'h00, 5'h01, 5'h08, 5'h11, 5'h12, 5'h14, 5'h18
  };

endpackage

// ===== src/smid_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smid_match
// Table match stage: turns a classified instruction word into its dense
// opcode, known flag and register-use flag.
// ----------------------------------------------------------------------------
module smid_match (
  input  logic [smid_pkg::WORD_W-1:0] word,
  input  smid_pkg::cls_t              cls,
  output smid_pkg::match_t            match
);

  always_comb begin
    match.opc      = smid_pkg::OPC_UNKNOWN;
    match.known    = 1'b0;
    match.reg_used = 1'b0;
    unique case (cls)
      smid_pkg::CLS_MISC: begin
        for (int i = 0; i < smid_pkg::MISC_COUNT; i++) begin
          if (word == smid_pkg::MISC_WORDS[i]) begin
            match.opc   = smid_pkg::OPC_MISC_BASE + 7'(i);
            match.known = 1'b1;
          end
        end
      end
      smid_pkg::CLS_REG: begin
        for (int i = 0; i < smid_pkg::REG_COUNT; i++) begin
          if ((word & smid_pkg::REG_KEY_MASK) == smid_pkg::REG_KEYS[i]) begin
            match.opc      = smid_pkg::OPC_REG_BASE + 7'(i);
            match.known    = 1'b1;
            match.reg_used = smid_pkg::REG_USES[i];
          end
        end
      end
      smid_pkg::CLS_MID: begin
        for (int i = 0; i < smid_pkg::MID_COUNT; i++) begin
          if (word[12:8] == smid_pkg::MID_KEYS[i]) begin
            match.opc   = smid_pkg::OPC_MID_BASE + 7'(i);
            match.known = 1'b1;
          end
        end
      end
      smid_pkg::CLS_MVI: begin
        match.opc   = smid_pkg::OPC_MVI;
        match.known = 1'b1;
      end
      smid_pkg::CLS_JMP: begin
        match.opc   = smid_pkg::OPC_JMP;
        match.known = 1'b1;
      end
      smid_pkg::CLS_CALL: begin
        match.opc   = smid_pkg::OPC_CALL;
        match.known = 1'b1;
      end
      smid_pkg::CLS_K: begin
        if (word[12:9] <= smid_pkg::K_SEL_LAST) begin
          match.opc   = smid_pkg::OPC_K_BASE + {3'b000, word[12:9]};
          match.known = 1'b1;
        end else if (word[12:9] == smid_pkg::K_SEL_TADI5) begin
          match.opc   = smid_pkg::OPC_K_TADI5;
          match.known = 1'b1;
        end
      end
      smid_pkg::CLS_P: begin
        match.known = 1'b1;
        if (word[14:13] == 2'b10) begin
          match.opc = smid_pkg::OPC_P_REG_BASE + {3'b000, word[12:9]};
        end else begin
          match.opc = smid_pkg::OPC_P_IMM_BASE + {3'b000, word[12:9]};
        end
      end
      default: begin
        match.opc = smid_pkg::OPC_UNKNOWN;
      end
    endcase
  end

endmodule

// ===== src/sound_mcu_instruction_decoder.sv =====
`timescale 1ns / 1ps
// A beat passes the stage 1, 2 and 3 registers to out_valid. Throughput: one
// word per cycle while out_ready is high; three register stages (byte swap and
// class decode, opcode table match, operand field format) run concurrently.
// A stalled output holds its stage; earlier empty stages keep accepting.
// Reset (synchronous, rst_n low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// sound_mcu_instruction_decoder
// Pipelined decoder for one 16-bit ROM word of a small sound MCU.
// ----------------------------------------------------------------------------
module sound_mcu_instruction_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [smid_pkg::WORD_W-1:0]   in_rom_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [smid_pkg::OPC_W-1:0]    out_op_code,
  output logic [smid_pkg::FORM_W-1:0]   out_operand_form,
  output logic [smid_pkg::REG_W-1:0]    out_reg_field,
  output logic [smid_pkg::IMM_W-1:0]    out_imm_field,
  output logic                          out_known,
  output logic [smid_pkg::BRANCH_W-1:0] out_branch_kind,
  output logic                          out_target_in_rom
);

  logic en1, en2, en3;

  logic                        s1_v_r, s2_v_r, s3_v_r;
  logic [smid_pkg::WORD_W-1:0] s1_word_r, s2_word_r;
  smid_pkg::cls_t              s1_cls_r, s2_cls_r;
  smid_pkg::match_t            s2_match_r;

  logic [smid_pkg::WORD_W-1:0] s1_word_nxt;
  smid_pkg::cls_t              s1_cls_nxt;
  smid_pkg::match_t            s2_match_nxt;

  logic [smid_pkg::OPC_W-1:0]    opc_r, opc_nxt;
  logic [smid_pkg::FORM_W-1:0]   form_r, form_nxt;
  logic [smid_pkg::REG_W-1:0]    reg_r, reg_nxt;
  logic [smid_pkg::IMM_W-1:0]    imm_r, imm_nxt;
  logic                          known_r, known_nxt;
  logic [smid_pkg::BRANCH_W-1:0] br_r, br_nxt;
  logic                          inrom_r, inrom_nxt;

  assign en3      = !s3_v_r || out_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  // stage 1: byte swap, class
  assign s1_word_nxt = {in_rom_word[7:0], in_rom_word[15:8]};

  always_comb begin
    unique case (s1_word_nxt[15:12]) inside
      4'h0:             s1_cls_nxt = smid_pkg::CLS_MISC;
      4'h1:             s1_cls_nxt = smid_pkg::CLS_REG;
      4'h2, 4'h3:       s1_cls_nxt = smid_pkg::CLS_MID;
      4'h4, 4'h5:       s1_cls_nxt = smid_pkg::CLS_MVI;
      4'h6:             s1_cls_nxt = smid_pkg::CLS_JMP;
      4'h7:             s1_cls_nxt = smid_pkg::CLS_CALL;
      4'hE, 4'hF:       s1_cls_nxt = smid_pkg::CLS_K;
      default:          s1_cls_nxt = smid_pkg::CLS_P;
    endcase
  end

  // stage 2: table match
  smid_match u_match (
    .word  (s1_word_r),
    .cls   (s1_cls_r),
    .match (s2_match_nxt)
  );

  // stage 3: operand fields
  always_comb begin
    opc_nxt   = s2_match_r.opc;
    known_nxt = s2_match_r.known;
    form_nxt  = smid_pkg::FORM_NONE;
    reg_nxt   = '0;
    imm_nxt   = '0;
    br_nxt    = smid_pkg::BR_NONE;
    inrom_nxt = 1'b0;
    unique case (s2_cls_r)
      smid_pkg::CLS_MISC: begin
        form_nxt = smid_pkg::FORM_NONE;
      end
      smid_pkg::CLS_REG: begin
        if (s2_match_r.reg_used) begin
          form_nxt = smid_pkg::FORM_REG;
          reg_nxt  = s2_word_r[8:4];
        end
      end
      smid_pkg::CLS_MID: begin
        form_nxt = smid_pkg::FORM_IMM;
        imm_nxt  = {4'h0, s2_word_r[7:0]};
      end
      smid_pkg::CLS_MVI: begin
        form_nxt = smid_pkg::FORM_REG_IMM;
        reg_nxt  = s2_word_r[12:8];
        imm_nxt  = {4'h0, s2_word_r[7:0]};
      end
      smid_pkg::CLS_JMP, smid_pkg::CLS_CALL: begin
        form_nxt  = smid_pkg::FORM_IMM;
        imm_nxt   = s2_word_r[11:0];
        br_nxt    = (s2_cls_r == smid_pkg::CLS_JMP) ? smid_pkg::BR_JUMP : smid_pkg::BR_CALL;
        inrom_nxt = s2_word_r[11:0] < smid_pkg::ROM_LIMIT;
      end
      smid_pkg::CLS_K: begin
        form_nxt = smid_pkg::FORM_REG_IMM;
        reg_nxt  = s2_word_r[8:4];
        imm_nxt  = {8'h00, s2_word_r[3:0]};
      end
      smid_pkg::CLS_P: begin
        case (s2_word_r[14:13])
          2'b00: begin
            if (!s2_word_r[8]) begin
              form_nxt = smid_pkg::FORM_A_IMM;
              imm_nxt  = {4'h0, s2_word_r[7:0]};
            end else if (s2_word_r[12]) begin
              form_nxt = smid_pkg::FORM_MD_IMM;
              imm_nxt  = {4'h0, s2_word_r[7:0]};
            end else begin
              form_nxt = smid_pkg::FORM_MD1_IMM;
              imm_nxt  = {9'h000, s2_word_r[7:5]};
            end
          end
          2'b01: begin
            form_nxt = s2_word_r[8] ? smid_pkg::FORM_H_IMM : smid_pkg::FORM_HIND_IMM;
            imm_nxt  = {4'h0, s2_word_r[7:0]};
          end
          default: begin
            case (s2_word_r[3:0])
              smid_pkg::RM_A_HIND: form_nxt = smid_pkg::FORM_A_HIND;
              smid_pkg::RM_HIND_A: form_nxt = smid_pkg::FORM_HIND_A;
              smid_pkg::RM_A_REG: begin
                form_nxt = smid_pkg::FORM_A_REG;
                reg_nxt  = s2_word_r[8:4];
              end
              smid_pkg::RM_REG_A: begin
                form_nxt = smid_pkg::FORM_REG_A;
                reg_nxt  = s2_word_r[8:4];
              end
              default: form_nxt = smid_pkg::FORM_UNDEF;
            endcase
          end
        endcase
      end
      default: begin
        form_nxt = smid_pkg::FORM_NONE;
      end
    endcase
    if (!s2_match_r.known) begin
      opc_nxt   = smid_pkg::OPC_UNKNOWN;
      form_nxt  = smid_pkg::FORM_NONE;
      reg_nxt   = '0;
      imm_nxt   = '0;
      br_nxt    = smid_pkg::BR_NONE;
      inrom_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_word_r <= s1_word_nxt;
      s1_cls_r  <= s1_cls_nxt;
    end
    if (en2) begin
      s2_word_r  <= s1_word_r;
      s2_cls_r   <= s1_cls_r;
      s2_match_r <= s2_match_nxt;
    end
    if (en3) begin
      opc_r   <= opc_nxt;
      form_r  <= form_nxt;
      reg_r   <= reg_nxt;
      imm_r   <= imm_nxt;
      known_r <= known_nxt;
      br_r    <= br_nxt;
      inrom_r <= inrom_nxt;
    end
  end

  assign out_valid         = s3_v_r;
  assign out_op_code       = opc_r;
  assign out_operand_form  = form_r;
  assign out_reg_field     = reg_r;
  assign out_imm_field     = imm_r;
  assign out_known         = known_r;
  assign out_branch_kind   = br_r;
  assign out_target_in_rom = inrom_r;

  a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_known |->
      out_op_code == smid_pkg::OPC_UNKNOWN && out_operand_form == smid_pkg::FORM_NONE &&
      out_reg_field == '0 && out_imm_field == '0)
    else $error("unknown word with nonzero fields");

  a_inrom_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_branch_kind == smid_pkg::BR_NONE |-> !out_target_in_rom)
    else $error("target_in_rom set without a branch");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_v_r && s2_v_r && s3_v_r && !out_ready)
    else $error("input blocked while a stage is free");

  a_stage1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !en2 |=> s1_v_r && $stable(s1_word_r))
    else $error("stalled stage 1 beat lost or changed");

endmodule
